[sv/adc_readout_sequencer_validator_top_assert.svh]
// Assertion macros for the ADC readout sequencer and validator.
// Included inside the top level; expects clk and rst in scope.
`ifndef ADC_READOUT_SEQUENCER_VALIDATOR_TOP_ASSERT_SVH
`define ADC_READOUT_SEQUENCER_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ARSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ARSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/arsv_pkg.sv]
// Package for the ADC readout sequencer and validator: types, codes, constants.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package arsv_pkg;

  localparam int FRAMES_PER_BATCH = 3;
  localparam int CHANNEL_COUNT    = 3;
  localparam int FRAME_IDX_W      = (FRAMES_PER_BATCH > 1) ? $clog2(FRAMES_PER_BATCH) : 1;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int RES_DEPTH   = 4;
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_THRESHOLD = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS    = CFG_INDEX_W'(1);

  localparam logic [15:0] ERROR_THRESHOLD_RESET = 16'd100;
  localparam logic [7:0]  SETTLE_TICKS_RESET    = 8'd1;

  localparam logic [15:0] PARITY_LUT   = 16'h6996;
  localparam logic [7:0]  PARITY_MASK  = 8'b0001_0000;
  localparam logic [7:0]  FLAG_MASK    = 8'b1110_0000;
  localparam logic [7:0]  CHANNEL_MASK = 8'b0000_1111;
  localparam logic [15:0] ERR_MAX      = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_LINE      = 2'd1,
    CMD_XFER_DONE = 2'd2,
    CMD_RESET_REQ = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    SQ_WRITE_RESET    = 3'd0,
    SQ_WAIT_SETTLE    = 3'd1,
    SQ_WRITE_SETTINGS = 3'd2,
    SQ_WRITE_SECOND   = 3'd3,
    SQ_IDLE           = 3'd4,
    SQ_WAIT_READY     = 3'd5,
    SQ_READING        = 3'd6
  } seq_state_t;

  typedef enum logic [2:0] {
    ACT_RESET    = 3'd0,
    ACT_SETTINGS = 3'd1,
    ACT_READ     = 3'd2,
    ACT_LED      = 3'd3,
    ACT_SAMPLE   = 3'd4
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [1:0]  channel;
    logic [15:0] torque;
    logic [15:0] errors_seen;
    logic        last;
  } result_t;

  // Saturating increment of the error count.
  function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic inc);
    sat_inc = (inc && (v != ERR_MAX)) ? v + 16'd1 : v;
  endfunction

endpackage

`default_nettype wire

[sv/arsv_if.sv]
// Channel interfaces for the ADC readout sequencer: event input, result output,
// configuration write. Depend on arsv_pkg.
`default_nettype none

interface arsv_evt_if;
  logic            valid;
  logic            ready;
  arsv_pkg::cmd_t  command;
  logic            line_level;
  logic [7:0]      data_high;
  logic [7:0]      data_middle;
  logic [7:0]      data_low;
  logic [7:0]      status_byte;

  modport source (output valid, command, line_level, data_high, data_middle, data_low,
                  status_byte, input ready);
  modport sink   (input valid, command, line_level, data_high, data_middle, data_low,
                  status_byte, output ready);
endinterface

interface arsv_res_if;
  logic                valid;
  logic                ready;
  arsv_pkg::action_t   action;
  logic [1:0]          channel;
  logic [15:0]         torque;
  logic [15:0]         errors_seen;
  logic                last;

  modport source (output valid, action, channel, torque, errors_seen, last, input ready);
  modport sink   (input valid, action, channel, torque, errors_seen, last, output ready);
endinterface

interface arsv_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [arsv_pkg::CFG_INDEX_W-1:0]    index;
  logic [arsv_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/adc_readout_sequencer_validator_top.sv]
// Top level of the ADC readout sequencer and frame validator.
// Depends on arsv_pkg, the channel interfaces in arsv_if.sv and the assertion header.
`default_nettype none

// Usage:
//   evt : one item per event: tick, data line change, transfer complete or reset
//         request, with the received frame bytes for a transfer complete.
//   res : zero, one or two result items per event item (command to send to the
//         converter, or a validated sample); last marks the final one of an item.
//   cfg : register writes (index 0 error threshold, index 1 settle ticks), always
//         ready; write only while no event item is in flight.
// Order: an event item is held in the input register, then its results are
//   written to a four-entry result queue, from whose head res is driven.
// Throughput: one event item per cycle while the queue has room for two more
//   results; the two results of an item (a sample followed by a forced reset)
//   leave one after the other through the single read port of the result queue.
// Reset: rst puts the sequencer into the writing-reset state with zero counters,
//   loads register defaults (threshold 100, settle ticks 1) and empties the queue.
// Stall: when res.ready is low the queue holds; once it cannot take two more
//   results the input register holds and evt.ready drops.
module adc_readout_sequencer_validator_top (
  input  wire logic          clk,
  input  wire logic          rst,
  arsv_evt_if.sink           evt,
  arsv_res_if.source         res,
  arsv_cfg_if.sink           cfg
);
  import arsv_pkg::*;

  // Configuration registers.
  logic [15:0] error_threshold;
  logic [7:0]  settle_ticks;

  // Sequencer state.
  seq_state_t              seq_state, seq_state_next;
  logic [7:0]              settle_count, settle_count_next;
  logic [15:0]             error_count, error_count_next;
  logic [FRAME_IDX_W-1:0]  frame_index, frame_index_next;

  // Input register.
  logic        stage_valid;
  cmd_t        stage_cmd;
  logic        stage_lvl;
  logic [7:0]  stage_dh, stage_dm, stage_dl, stage_st;

  // Result queue.
  result_t                res_mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]   rd_ptr, wr_ptr;
  logic [RES_CNT_W-1:0]   res_count, count_after_pop;
  logic                   pop, room, advance, evt_take;

  // Results produced by the item in the input register.
  result_t     r0, r1;
  logic [1:0]  n_res;

  // Frame check terms.
  logic [7:0]  fx;
  logic [3:0]  fx4;
  logic        frame_zero, parity_ok, flags_set, ch_ok, sample_ok, batch_wrap, forced;
  logic [3:0]  ch_code;
  logic [15:0] err_a, err_b;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_threshold <= ERROR_THRESHOLD_RESET;
      settle_ticks    <= SETTLE_TICKS_RESET;
    end else if (cfg.valid) begin
      // Ignore indexes beyond the register list.
      if (cfg.index == REG_ERROR_THRESHOLD) begin
        error_threshold <= cfg.data[15:0];
      end else if (cfg.index == REG_SETTLE_TICKS) begin
        settle_ticks <= cfg.data[7:0];
      end
    end
  end

  // Queue flow: pop one per cycle, push up to two when there is room for two.
  assign pop             = res.valid && res.ready;
  assign count_after_pop = res_count - RES_CNT_W'(pop);
  assign room            = count_after_pop <= RES_CNT_W'(RES_DEPTH - 2);
  assign advance         = stage_valid && room;
  assign evt.ready       = !stage_valid || advance;
  assign evt_take        = evt.valid && evt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= evt_take || (stage_valid && !advance);
    end
  end

  // Payload of the input register; hold while stalled.
  always_ff @(posedge clk) begin
    if (evt_take) begin
      stage_cmd <= evt.command;
      stage_lvl <= evt.line_level;
      stage_dh  <= evt.data_high;
      stage_dm  <= evt.data_middle;
      stage_dl  <= evt.data_low;
      stage_st  <= evt.status_byte;
    end
  end

  // Frame checks: parity over the 24 data bits against status bit 4, then flags,
  // then channel code. An all-zero frame counts one extra error.
  always_comb begin
    fx         = stage_dh ^ stage_dm ^ stage_dl;
    fx4        = fx[7:4] ^ fx[3:0];
    parity_ok  = PARITY_LUT[fx4] == ((stage_st & PARITY_MASK) != 8'd0);
    flags_set  = (stage_st & FLAG_MASK) != 8'd0;
    ch_code    = 4'(stage_st & CHANNEL_MASK);
    ch_ok      = (32'(ch_code) < CHANNEL_COUNT) && (ch_code <= 4'd3);
    frame_zero = (stage_dh == 8'd0) && (stage_dm == 8'd0) && (stage_dl == 8'd0)
                 && (stage_st == 8'd0);
    sample_ok  = parity_ok && !flags_set && ch_ok;
    err_a      = sat_inc(error_count, frame_zero);
    err_b      = sat_inc(err_a, !sample_ok);
    batch_wrap = frame_index == FRAME_IDX_W'(FRAMES_PER_BATCH - 1);
    forced     = batch_wrap && (err_b > error_threshold);
  end

  // Next state and results for the item in the input register.
  always_comb begin
    seq_state_next    = seq_state;
    settle_count_next = settle_count;
    error_count_next  = error_count;
    frame_index_next  = frame_index;
    n_res             = 2'd0;
    r0                = '{action: ACT_RESET, channel: 2'd0, torque: 16'd0,
                          errors_seen: error_count, last: 1'b0};
    r1                = '{action: ACT_RESET, channel: 2'd0, torque: 16'd0,
                          errors_seen: 16'd0, last: 1'b0};

    unique case (stage_cmd)
      CMD_TICK: begin
        if (seq_state == SQ_IDLE) begin
          seq_state_next = SQ_WAIT_READY;
        end else if (seq_state == SQ_WAIT_SETTLE) begin
          if (settle_count < settle_ticks) begin
            settle_count_next = settle_count + 8'd1;
          end else begin
            seq_state_next = SQ_WRITE_SETTINGS;
            r0.action      = ACT_SETTINGS;
            n_res          = 2'd1;
          end
        end
      end
      CMD_LINE: begin
        if (seq_state == SQ_WAIT_READY && !stage_lvl) begin
          seq_state_next = SQ_READING;
          r0.action      = ACT_READ;
          n_res          = 2'd1;
        end
      end
      CMD_XFER_DONE: begin
        unique case (seq_state)
          SQ_WRITE_RESET: begin
            seq_state_next = SQ_WAIT_SETTLE;
          end
          SQ_WRITE_SETTINGS: begin
            seq_state_next = SQ_WRITE_SECOND;
            r0.action      = ACT_LED;
            n_res          = 2'd1;
          end
          SQ_READING: begin
            // Batch check on wrap; a forced reset clears the count.
            frame_index_next = batch_wrap ? '0 : frame_index + FRAME_IDX_W'(1);
            error_count_next = forced ? 16'd0 : err_b;
            if (forced) begin
              seq_state_next    = SQ_WRITE_RESET;
              settle_count_next = 8'd0;
            end else begin
              seq_state_next = SQ_WAIT_READY;
            end
            if (sample_ok) begin
              r0 = '{action: ACT_SAMPLE, channel: ch_code[1:0],
                     torque: {stage_dh, stage_dm}, errors_seen: err_b, last: 1'b0};
              n_res = forced ? 2'd2 : 2'd1;
            end else if (forced) begin
              r0.errors_seen = 16'd0;
              n_res          = 2'd1;
            end
          end
          default: begin
            seq_state_next = SQ_IDLE;
          end
        endcase
      end
      CMD_RESET_REQ: begin
        seq_state_next    = SQ_WRITE_RESET;
        settle_count_next = 8'd0;
        n_res             = 2'd1;
      end
    endcase

    r0.last = n_res == 2'd1;
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state    <= SQ_WRITE_RESET;
      settle_count <= 8'd0;
      error_count  <= 16'd0;
      frame_index  <= '0;
    end else if (advance) begin
      seq_state    <= seq_state_next;
      settle_count <= settle_count_next;
      error_count  <= error_count_next;
      frame_index  <= frame_index_next;
    end
  end

  // Result queue pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      res_count <= '0;
    end else begin
      rd_ptr    <= rd_ptr + RES_PTR_W'(pop);
      wr_ptr    <= wr_ptr + (advance ? RES_PTR_W'(n_res) : RES_PTR_W'(0));
      res_count <= count_after_pop + (advance ? RES_CNT_W'(n_res) : RES_CNT_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (advance && n_res != 2'd0) begin
      res_mem[wr_ptr] <= r0;
    end
    if (advance && n_res == 2'd2) begin
      res_mem[wr_ptr + RES_PTR_W'(1)] <= r1;
    end
  end

  assign res.valid       = res_count != '0;
  assign res.action      = res_mem[rd_ptr].action;
  assign res.channel     = res_mem[rd_ptr].channel;
  assign res.torque      = res_mem[rd_ptr].torque;
  assign res.errors_seen = res_mem[rd_ptr].errors_seen;
  assign res.last        = res_mem[rd_ptr].last;

  `include "adc_readout_sequencer_validator_top_assert.svh"

  `ARSV_ASSERT_NOW(a_queue_bound, 1'b1, res_count <= RES_CNT_W'(RES_DEPTH),
                   "result queue count beyond its depth")
  `ARSV_ASSERT_NOW(a_sample_channel, res.valid && res.action == ACT_SAMPLE,
                   32'(res.channel) < CHANNEL_COUNT, "sample with channel out of range")
  `ARSV_ASSERT_NOW(a_command_zero_payload, res.valid && res.action != ACT_SAMPLE,
                   res.channel == 2'd0 && res.torque == 16'd0,
                   "command result with nonzero sample fields")
  `ARSV_ASSERT_NEXT(a_state_holds, !rst && !advance, $stable(seq_state) &&
                    $stable(error_count), "sequencer state moved without an item")

endmodule

`default_nettype wire

[test/adc_readout_sequencer_validator_top_tb.sv]
// Testbench for adc_readout_sequencer_validator_top: a directed event table, then random
// readout sequences with noise, results checked against typed values or a behavioral model.
// Depends on arsv_pkg, the channel interfaces in arsv_if.sv and the top level.
`timescale 1ns / 1ps

module adc_readout_sequencer_validator_top_tb;
  import arsv_pkg::*;

  // Index outside the register list; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = CFG_INDEX_W'(15);
  localparam int RANDOM_ITEMS_PER_PHASE = 280;
  localparam int NOISE_PCT = 8;
  localparam int SETTLE_CYCLES = 4;   // input register plus queue write, with margin
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  // One event item as the sender sees it.
  typedef struct packed {
    cmd_t       command;
    logic       line_level;
    logic [7:0] data_high;
    logic [7:0] data_middle;
    logic [7:0] data_low;
    logic [7:0] status_byte;
  } event_t;

  // One row of the directed table: either a register write or an event item,
  // optionally with its single result typed in.
  typedef struct packed {
    logic                   is_write;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    event_t                 item;
    logic                   typed;
    result_t                want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  arsv_evt_if evt ();
  arsv_res_if res ();
  arsv_cfg_if cfg ();

  adc_readout_sequencer_validator_top uut (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .res (res),
    .cfg (cfg)
  );

  always #10 clk = ~clk;

  // Bench copy of the sequencer: registers, state and the results of the current item.
  logic [15:0] model_threshold;
  logic [7:0]  model_settle_ticks;
  seq_state_t  model_seq;
  logic [7:0]  model_settle_count;
  logic [15:0] model_errors;
  int          model_frame;
  logic        model_batch_filled;
  result_t     staged [2];
  int          staged_count;

  // Results owed by the block, oldest first.
  result_t     pending_actions [$];
  int          mismatches = 0;
  int          src_gap_pct;
  int          sink_stall_pct;
  plan_row_t   plan [$];

  // Record one result of the current item; errors_seen is the count right now.
  function automatic void stage(action_t act, logic [1:0] chan, logic [15:0] torque);
    staged[staged_count] = '{act, chan, torque, model_errors, 1'b0};
    staged_count++;
  endfunction

  // Bump the error count, holding at the ceiling.
  function automatic void count_error();
    if (model_errors != ERR_MAX) model_errors++;
  endfunction

  // Send the converter back to reset; the error count and frame index survive.
  function automatic void restart_converter();
    model_seq = SQ_WRITE_RESET;
    model_settle_count = '0;
    model_batch_filled = 1'b0;
    stage(ACT_RESET, 2'd0, 16'd0);
  endfunction

  // Advance the sequencer by one event item and stage the results it causes.
  function automatic void advance_sequencer(event_t e);
    logic [3:0] chan;
    staged_count = 0;
    chan = e.status_byte[3:0];
    case (e.command)
      CMD_TICK: begin
        if (model_seq == SQ_IDLE) begin
          model_seq = SQ_WAIT_READY;
        end else if (model_seq == SQ_WAIT_SETTLE) begin
          if (model_settle_count < model_settle_ticks) begin
            model_settle_count++;
          end else begin
            model_seq = SQ_WRITE_SETTINGS;
            stage(ACT_SETTINGS, 2'd0, 16'd0);
          end
        end
      end
      CMD_LINE: begin
        if (model_seq == SQ_WAIT_READY && !e.line_level) begin
          model_seq = SQ_READING;
          stage(ACT_READ, 2'd0, 16'd0);
        end
      end
      CMD_XFER_DONE: begin
        case (model_seq)
          SQ_WRITE_RESET: model_seq = SQ_WAIT_SETTLE;
          SQ_WRITE_SETTINGS: begin
            model_seq = SQ_WRITE_SECOND;
            stage(ACT_LED, 2'd0, 16'd0);
          end
          SQ_READING: begin
            model_seq = SQ_WAIT_READY;
            // An empty frame costs one error but is still judged.
            if ({e.data_high, e.data_middle, e.data_low, e.status_byte} == 32'd0)
              count_error();
            // Status bit 4 carries the parity of the 24 data bits.
            if ((^{e.data_high, e.data_middle, e.data_low}) != e.status_byte[4])
              count_error();
            else if ((e.status_byte & FLAG_MASK) != 8'd0)
              count_error();
            else if (chan >= CHANNEL_COUNT || chan > 4'd3)
              count_error();
            else
              stage(ACT_SAMPLE, chan[1:0], {e.data_high, e.data_middle});
            model_frame++;
            if (model_frame >= FRAMES_PER_BATCH) begin
              model_frame = 0;
              model_batch_filled = 1'b1;
              if (model_errors > model_threshold) begin
                model_errors = '0;
                restart_converter();
              end
            end
          end
          default: model_seq = SQ_IDLE;
        endcase
      end
      CMD_RESET_REQ: restart_converter();
    endcase
    if (staged_count > 0) staged[staged_count - 1].last = 1'b1;
  endfunction

  // Table row builders.
  function automatic plan_row_t event_row(cmd_t c, logic lvl, logic [31:0] frame);
    event_row = '0;
    event_row.item = '{c, lvl, frame[31:24], frame[23:16], frame[15:8], frame[7:0]};
  endfunction

  function automatic plan_row_t checked_row(cmd_t c, logic lvl, logic [31:0] frame,
                                            action_t act, logic [1:0] chan,
                                            logic [15:0] torque, logic [15:0] errs);
    checked_row = event_row(c, lvl, frame);
    checked_row.typed = 1'b1;
    checked_row.want = '{act, chan, torque, errs, 1'b1};
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    reg_row = '0;
    reg_row.is_write = 1'b1;
    reg_row.reg_index = idx;
    reg_row.reg_value = val;
  endfunction

  // Pick the next event: mostly the one that moves the sequence on, with random
  // frame content; the rest is noise. With spoil set, every frame but noise fails parity.
  function automatic event_t next_event(int noise_pct, logic spoil);
    event_t e;
    int roll;
    e.command = CMD_TICK;
    e.line_level = 1'($urandom);
    e.data_high = 8'($urandom);
    e.data_middle = 8'($urandom);
    e.data_low = 8'($urandom);
    e.status_byte = 8'($urandom);
    if ($urandom_range(0, 99) < noise_pct) begin
      e.command = cmd_t'($urandom_range(0, 3));
      // A long settle would never finish if reset requests kept cutting it short.
      if (e.command == CMD_RESET_REQ && model_seq == SQ_WAIT_SETTLE &&
          model_settle_ticks > 8'd16)
        e.command = CMD_TICK;
      return e;
    end
    case (model_seq)
      SQ_WAIT_SETTLE, SQ_IDLE: e.command = CMD_TICK;
      SQ_WAIT_READY: begin
        e.command = CMD_LINE;
        e.line_level = ($urandom_range(0, 9) == 0);
      end
      SQ_READING: begin
        e.command = CMD_XFER_DONE;
        roll = $urandom_range(0, 99);
        if (roll < 3 && !spoil) begin
          {e.data_high, e.data_middle, e.data_low, e.status_byte} = 32'd0;
        end else begin
          e.status_byte[7:5] = (roll < 15) ? 3'($urandom_range(1, 7)) : 3'd0;
          e.status_byte[3:0] = (roll < 25) ? 4'($urandom_range(3, 15))
                                           : 4'($urandom_range(0, 2));
          e.status_byte[4] = (^{e.data_high, e.data_middle, e.data_low}) ^
                             (spoil || roll >= 92);
        end
      end
      default: e.command = CMD_XFER_DONE;
    endcase
    return e;
  endfunction

  // Offer one event item, with random gaps in front; on acceptance book its results.
  // Enter and leave at a falling edge; valid stays up for a following item.
  task automatic send_event(input event_t e, input logic typed, input result_t want);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      evt.valid = 1'b0;
      @(negedge clk);
    end
    evt.valid = 1'b1;
    evt.command = e.command;
    evt.line_level = e.line_level;
    evt.data_high = e.data_high;
    evt.data_middle = e.data_middle;
    evt.data_low = e.data_low;
    evt.status_byte = e.status_byte;
    do @(posedge clk); while (!evt.ready);
    advance_sequencer(e);
    if (typed) begin
      pending_actions.push_back(want);
    end else begin
      for (int i = 0; i < staged_count; i++) pending_actions.push_back(staged[i]);
    end
    @(negedge clk);
  endtask

  // Write a register once the block has gone quiet: nothing owed, and enough
  // cycles for an item without results to have passed through.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    evt.valid = 1'b0;
    while (pending_actions.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_ERROR_THRESHOLD: model_threshold = val;
      REG_SETTLE_TICKS: model_settle_ticks = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Receiver: stall at random, at the rate of the current phase.
  always @(negedge clk) begin
    res.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Compare every accepted result with the oldest one owed.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && res.valid && res.ready) begin
      got = '{res.action, res.channel, res.torque, res.errors_seen, res.last};
      if (pending_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: act=%0d ch=%0d tq=%h err=%0d last=%0d",
                   got.action, got.channel, got.torque, got.errors_seen, got.last);
      end else begin
        want = pending_actions.pop_front();
        if (got.action !== want.action || got.channel !== want.channel ||
            got.torque !== want.torque || got.errors_seen !== want.errors_seen ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result mismatch: want act=%0d ch=%0d tq=%h err=%0d last=%0d",
                     want.action, want.channel, want.torque, want.errors_seen,
                     want.last);
            $display("                  got act=%0d ch=%0d tq=%h err=%0d last=%0d",
                     got.action, got.channel, got.torque, got.errors_seen, got.last);
          end
        end
      end
    end
  end

  initial begin
    logic [15:0] thr;
    logic [7:0]  settle;

    // Hold every input at a known value from time zero.
    evt.valid = 1'b0;
    evt.command = CMD_TICK;
    evt.line_level = 1'b0;
    evt.data_high = '0;
    evt.data_middle = '0;
    evt.data_low = '0;
    evt.status_byte = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    res.ready = 1'b0;

    model_threshold = ERROR_THRESHOLD_RESET;
    model_settle_ticks = SETTLE_TICKS_RESET;
    model_seq = SQ_WRITE_RESET;
    model_settle_count = '0;
    model_errors = '0;
    model_frame = 0;
    model_batch_filled = 1'b0;
    src_gap_pct = 15;
    sink_stall_pct = 60;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed walk with register defaults: full bring-up, every frame verdict,
    // then a low threshold so a good frame closing a batch brings a forced reset.
    plan = '{
      checked_row(CMD_RESET_REQ, 1'b0, 32'd0, ACT_RESET, 2'd0, 16'd0, 16'd0),
      event_row(CMD_XFER_DONE, 1'b0, 32'd0),             // reset written, settle
      event_row(CMD_TICK, 1'b0, 32'd0),                  // count one tick
      checked_row(CMD_TICK, 1'b0, 32'd0, ACT_SETTINGS, 2'd0, 16'd0, 16'd0),
      checked_row(CMD_XFER_DONE, 1'b0, 32'd0, ACT_LED, 2'd0, 16'd0, 16'd0),
      event_row(CMD_XFER_DONE, 1'b0, 32'd0),             // second write done, idle
      event_row(CMD_LINE, 1'b0, 32'd0),                  // line change while idle: drop
      event_row(CMD_TICK, 1'b0, 32'd0),                  // arm readout
      event_row(CMD_LINE, 1'b1, 32'd0),                  // line high: not ready
      checked_row(CMD_LINE, 1'b0, 32'd0, ACT_READ, 2'd0, 16'd0, 16'd0),
      checked_row(CMD_XFER_DONE, 1'b1, 32'hFFFFFF02, ACT_SAMPLE, 2'd2, 16'hFFFF, 16'd0),
      event_row(CMD_LINE, 1'b0, 32'd0),
      checked_row(CMD_XFER_DONE, 1'b0, 32'd0, ACT_SAMPLE, 2'd0, 16'd0, 16'd1),
      event_row(CMD_LINE, 1'b0, 32'd0),
      event_row(CMD_XFER_DONE, 1'b0, 32'h01000000),      // parity mismatch
      event_row(CMD_LINE, 1'b0, 32'd0),
      event_row(CMD_XFER_DONE, 1'b0, 32'h800000F0),      // all flags set
      event_row(CMD_LINE, 1'b0, 32'd0),
      event_row(CMD_XFER_DONE, 1'b0, 32'h12345613),      // channel code out of range
      event_row(CMD_XFER_DONE, 1'b0, 32'd0),             // done while waiting: idle
      reg_row(REG_ERROR_THRESHOLD, 16'd0),
      reg_row(REG_SETTLE_TICKS, 16'd0),
      reg_row(REG_UNMAPPED, 16'hFFFF),
      event_row(CMD_RESET_REQ, 1'b0, 32'd0),
      event_row(CMD_XFER_DONE, 1'b0, 32'd0),
      event_row(CMD_TICK, 1'b0, 32'd0),                  // zero settle: settings now
      event_row(CMD_XFER_DONE, 1'b0, 32'd0),
      event_row(CMD_XFER_DONE, 1'b0, 32'd0),
      event_row(CMD_TICK, 1'b0, 32'd0),
      event_row(CMD_LINE, 1'b0, 32'd0),
      event_row(CMD_XFER_DONE, 1'b0, 32'h12345611)       // sample, then forced reset
    };
    foreach (plan[i]) begin
      if (plan[i].is_write)
        write_register(plan[i].reg_index, plan[i].reg_value);
      else
        send_event(plan[i].item, plan[i].typed, plan[i].want);
    end

    // Random phases: sender gaps light and receiver stalls heavy, then the
    // reverse, then none. Each phase starts from its own register setting.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_gap_pct = 15;
          sink_stall_pct = 60;
          thr = 16'($urandom_range(0, 6));
          settle = 8'($urandom_range(0, 3));
        end
        1: begin
          src_gap_pct = 60;
          sink_stall_pct = 15;
          thr = 16'hFFFF;
          settle = 8'hFF;
        end
        default: begin
          src_gap_pct = 0;
          sink_stall_pct = 0;
          thr = 16'($urandom_range(0, 3));
          settle = 8'($urandom_range(0, 2));
        end
      endcase
      write_register(REG_ERROR_THRESHOLD, thr);
      write_register(REG_SETTLE_TICKS, 16'(settle));
      repeat (RANDOM_ITEMS_PER_PHASE) send_event(next_event(NOISE_PCT, 1'b0), 1'b0, '0);
    end

    evt.valid = 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_actions.size() == 0)
      $display("adc_readout_sequencer_validator_top_tb: done, clean");
    else
      $display("adc_readout_sequencer_validator_top_tb: done, errors");
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("adc_readout_sequencer_validator_top_tb: done, errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/arsv_pkg.sv
sv/arsv_if.sv
sv/adc_readout_sequencer_validator_top.sv
test/adc_readout_sequencer_validator_top_tb.sv
